@@ hdl/mbt_pkg.sv @@
package mbt_pkg;

    localparam int GRID_SIDE = 64;
    localparam int COORD_W   = 6;
    localparam int SIZE_W    = 7;
    localparam int CELL_W    = 12;
    localparam int RAND_W    = 8;

    localparam logic [SIZE_W-1:0] GRID_WIDTH_RESET  = 7'd50;
    localparam logic [SIZE_W-1:0] GRID_HEIGHT_RESET = 7'd50;

    localparam logic REG_GRID_WIDTH  = 1'b0;
    localparam logic REG_GRID_HEIGHT = 1'b1;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    typedef enum logic [1:0] {
        MOVE_CARVED,
        MOVE_BACKTRACK,
        MOVE_FINISHED,
        MOVE_STARTED
    } move_kind_t;

    typedef enum logic [1:0] {
        DIR_TOP,
        DIR_BOTTOM,
        DIR_EAST,
        DIR_WEST
    } dir_t;

    typedef struct packed {
        logic accept;
        logic rd_row;
        logic commit;
    } mbt_cmd_t;

    // Residue modulo 3 by folding base-4 digits, since 4 is congruent to 1.
    function automatic logic [1:0] mod3(input logic [RAND_W-1:0] value);
        logic [3:0] sum;
        logic [2:0] fold;
        sum  = 4'(value[1:0]) + 4'(value[3:2]) + 4'(value[5:4]) + 4'(value[7:6]);
        fold = 3'(sum[3:2]) + 3'(sum[1:0]);
        if (fold >= 3'd3)
        begin
            fold = fold - 3'd3;
        end
        if (fold >= 3'd3)
        begin
            fold = fold - 3'd3;
        end
        return fold[1:0];
    endfunction

    function automatic logic [1:0] pick_rank(input logic [RAND_W-1:0] value,
                                             input logic [2:0] count);
        logic [1:0] rank;
        unique case (count)
            3'd2:    rank = {1'b0, value[0]};
            3'd3:    rank = mod3(value);
            3'd4:    rank = value[1:0];
            default: rank = 2'd0;
        endcase
        return rank;
    endfunction

    // Direction of the open neighbour with the given rank, in scan order.
    function automatic dir_t nth_open(input logic [3:0] open_mask, input logic [1:0] rank);
        dir_t       dir;
        logic [1:0] seen;
        logic       found;
        dir   = DIR_TOP;
        seen  = 2'd0;
        found = 1'b0;
        for (int d = 0; d < 4; d++)
        begin
            if (open_mask[d] && !found)
            begin
                if (seen == rank)
                begin
                    dir   = dir_t'(d[1:0]);
                    found = 1'b1;
                end
                seen = seen + 2'd1;
            end
        end
        return dir;
    endfunction

endpackage

@@ hdl/mbt_ctrl.sv @@
module mbt_ctrl
    import mbt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    output mbt_cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ROW,
        S_DECIDE
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   out_free;

    // The result register is free when empty or when its transaction completes now.
    assign out_free   = !out_valid_reg || !out_stall;
    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign cmd.accept = (state_reg == S_IDLE) && in_valid;
    assign cmd.rd_row = (state_reg == S_ROW);
    assign cmd.commit = (state_reg == S_DECIDE) && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_ROW;
                    end
                end
                S_ROW:
                begin
                    state_reg <= S_DECIDE;
                end
                S_DECIDE:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

@@ hdl/mbt_datapath.sv @@
module mbt_datapath
    import mbt_pkg::*;
#(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  mbt_cmd_t           cmd,
    input  logic               action,
    input  logic [RAND_W-1:0]  rand_value,
    input  logic [SIZE_W-1:0]  width_lim,
    input  logic [SIZE_W-1:0]  height_lim,
    output logic [1:0]         move_kind,
    output logic [COORD_W-1:0] cell_x,
    output logic [COORD_W-1:0] cell_y,
    output logic [1:0]         carve_dir,
    output logic               finished
);

    localparam int LIM_COLS = (MAX_COLS < GRID_SIDE) ? MAX_COLS : GRID_SIDE;
    localparam int LIM_ROWS = (MAX_ROWS < GRID_SIDE) ? MAX_ROWS : GRID_SIDE;
    localparam int CW       = $clog2(LIM_COLS);
    localparam int RW       = $clog2(LIM_ROWS);
    localparam int SD       = LIM_COLS * LIM_ROWS;
    localparam int SW       = $clog2(SD);
    localparam int DW       = $clog2(SD + 1);

    localparam logic [SIZE_W-1:0] LIM_COLS_S = SIZE_W'(LIM_COLS);
    localparam logic [SIZE_W-1:0] LIM_ROWS_S = SIZE_W'(LIM_ROWS);
    localparam logic [DW-1:0]     SD_D       = DW'(SD);

    typedef logic [LIM_COLS-1:0] row_t;

    // Visited map: one row of the grid per word, each row with a valid flag.
    row_t             vis_mem [LIM_ROWS];
    logic [CELL_W-1:0] stack_mem [SD];

    logic [LIM_ROWS-1:0] row_valid_reg;
    row_t                rd_a_reg;
    row_t                rd_b_reg;
    logic                va_reg;
    logic                vb_reg;
    row_t                top_row_reg;
    row_t                bot_row_reg;
    logic [CELL_W-1:0]   stk_rd_reg;
    logic                act_reg;
    logic [RAND_W-1:0]   rnd_reg;

    logic [COORD_W-1:0]  cur_x_reg, cur_x_next;
    logic [COORD_W-1:0]  cur_y_reg, cur_y_next;
    logic [DW-1:0]       depth_reg, depth_next;
    logic                done_reg, done_next;
    logic                start_clear;

    move_kind_t          kind_reg, kind_next;
    dir_t                dir_reg, dir_next;
    logic                fin_reg, fin_next;

    logic [SIZE_W-1:0]   x_inc, x_dec, y_inc, y_dec;
    logic [RW-1:0]       top_idx, bot_idx, mid_idx, addr_a;
    logic [CW-1:0]       xi, xe, xw;
    logic                in_col, in_row;
    row_t                mid_row;
    logic [3:0]          open_mask;
    logic [2:0]          open_count;
    dir_t                pick_dir;
    logic [DW-1:0]       depth_dec;
    logic [SW-1:0]       pop_addr;

    logic                vis_we;
    logic [RW-1:0]       vis_waddr;
    row_t                vis_wdata;
    logic                stk_we;
    logic [COORD_W-1:0]  new_x, new_y;

    assign x_inc = {1'b0, cur_x_reg} + 7'd1;
    assign x_dec = {1'b0, cur_x_reg} - 7'd1;
    assign y_inc = {1'b0, cur_y_reg} + 7'd1;
    assign y_dec = {1'b0, cur_y_reg} - 7'd1;

    // Addresses past the grid are never used, so they are steered to row 0.
    assign mid_idx = cur_y_reg[RW-1:0];
    assign top_idx = (y_dec < LIM_ROWS_S) ? y_dec[RW-1:0] : '0;
    assign bot_idx = (y_inc < LIM_ROWS_S) ? y_inc[RW-1:0] : '0;
    assign addr_a  = cmd.rd_row ? mid_idx : top_idx;

    assign xi = cur_x_reg[CW-1:0];
    assign xe = (x_inc < LIM_COLS_S) ? x_inc[CW-1:0] : '0;
    assign xw = (x_dec < LIM_COLS_S) ? x_dec[CW-1:0] : '0;

    assign depth_dec = depth_reg - DW'(1);
    assign pop_addr  = depth_dec[SW-1:0];

    assign mid_row = va_reg ? rd_a_reg : '0;

    // A cell left outside a shrunken grid keeps the coordinate that is out of bounds,
    // so the unchanged coordinate of each neighbour is tested as well.
    assign in_col = ({1'b0, cur_x_reg} < width_lim);
    assign in_row = ({1'b0, cur_y_reg} < height_lim);

    assign open_mask[DIR_TOP]    = in_col && (cur_y_reg != '0) && (y_dec < height_lim) &&
                                   !top_row_reg[xi];
    assign open_mask[DIR_BOTTOM] = in_col && (y_inc < height_lim) && !bot_row_reg[xi];
    assign open_mask[DIR_EAST]   = in_row && (x_inc < width_lim) && !mid_row[xe];
    assign open_mask[DIR_WEST]   = in_row && (cur_x_reg != '0) && (x_dec < width_lim) &&
                                   !mid_row[xw];
    assign open_count = 3'($countones(open_mask));
    assign pick_dir   = nth_open(open_mask, pick_rank(rnd_reg, open_count));

    always_comb
    begin
        new_x = cur_x_reg;
        new_y = cur_y_reg;
        unique case (pick_dir)
            DIR_TOP:    new_y = y_dec[COORD_W-1:0];
            DIR_BOTTOM: new_y = y_inc[COORD_W-1:0];
            DIR_EAST:   new_x = x_inc[COORD_W-1:0];
            DIR_WEST:   new_x = x_dec[COORD_W-1:0];
            default:    new_x = cur_x_reg;
        endcase
    end

    always_comb
    begin
        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        depth_next  = depth_reg;
        done_next   = done_reg;
        kind_next   = kind_reg;
        dir_next    = dir_reg;
        fin_next    = fin_reg;
        start_clear = 1'b0;
        vis_we      = 1'b0;
        vis_waddr   = '0;
        vis_wdata   = '0;
        stk_we      = 1'b0;

        if (cmd.commit)
        begin
            dir_next = DIR_TOP;
            fin_next = 1'b0;
            priority if (act_reg == ACT_START)
            begin
                start_clear = 1'b1;
                vis_we      = 1'b1;
                vis_wdata   = row_t'(1);
                cur_x_next  = '0;
                cur_y_next  = '0;
                depth_next  = '0;
                done_next   = 1'b0;
                kind_next   = MOVE_STARTED;
            end
            else if (done_reg)
            begin
                kind_next = MOVE_FINISHED;
                fin_next  = 1'b1;
            end
            else if (open_count == 3'd0)
            begin
                if (depth_reg == '0)
                begin
                    done_next = 1'b1;
                    kind_next = MOVE_FINISHED;
                    fin_next  = 1'b1;
                end
                else
                begin
                    depth_next = depth_dec;
                    cur_x_next = stk_rd_reg[COORD_W-1:0];
                    cur_y_next = stk_rd_reg[CELL_W-1:COORD_W];
                    kind_next  = MOVE_BACKTRACK;
                end
            end
            else
            begin
                if (open_count >= 3'd2 && depth_reg < SD_D)
                begin
                    stk_we     = 1'b1;
                    depth_next = depth_reg + DW'(1);
                end
                cur_x_next = new_x;
                cur_y_next = new_y;
                kind_next  = MOVE_CARVED;
                dir_next   = pick_dir;
                vis_we     = 1'b1;
                vis_waddr  = new_y[RW-1:0];
                unique case (pick_dir)
                    DIR_TOP:    vis_wdata = top_row_reg;
                    DIR_BOTTOM: vis_wdata = bot_row_reg;
                    default:    vis_wdata = mid_row;
                endcase
                vis_wdata = vis_wdata | (row_t'(1) << new_x[CW-1:0]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept || cmd.rd_row)
        begin
            rd_a_reg <= vis_mem[addr_a];
            va_reg   <= row_valid_reg[addr_a];
        end
        if (cmd.accept)
        begin
            rd_b_reg   <= vis_mem[bot_idx];
            vb_reg     <= row_valid_reg[bot_idx];
            stk_rd_reg <= stack_mem[pop_addr];
            act_reg    <= action;
            rnd_reg    <= rand_value;
        end
        if (cmd.rd_row)
        begin
            top_row_reg <= va_reg ? rd_a_reg : '0;
            bot_row_reg <= vb_reg ? rd_b_reg : '0;
        end
        if (vis_we)
        begin
            vis_mem[vis_waddr] <= vis_wdata;
        end
        if (stk_we)
        begin
            stack_mem[depth_reg[SW-1:0]] <= {cur_y_reg, cur_x_reg};
        end
        kind_reg <= kind_next;
        dir_reg  <= dir_next;
        fin_reg  <= fin_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            depth_reg     <= '0;
            done_reg      <= 1'b1;
        end
        else
        begin
            if (start_clear)
            begin
                row_valid_reg <= LIM_ROWS'(1);
            end
            else if (vis_we)
            begin
                row_valid_reg[vis_waddr] <= 1'b1;
            end
            cur_x_reg <= cur_x_next;
            cur_y_reg <= cur_y_next;
            depth_reg <= depth_next;
            done_reg  <= done_next;
        end
    end

    assign move_kind = kind_reg;
    assign cell_x    = cur_x_reg;
    assign cell_y    = cur_y_reg;
    assign carve_dir = dir_reg;
    assign finished  = fin_reg;

endmodule

@@ hdl/maze_backtracker_step_core.sv @@
// Flow: an accepted item reads the neighbour rows of the visited-row memory, then the
// current row, and a decision state registers the result once the output register is
// free. Input stalls until that commit, so no new item is taken before the last is done.
// Reset: asynchronous, active low; grid size returns to 50 x 50, the maze reads as
// finished until a start item, and the visited map is cleared through row flags at once.
module maze_backtracker_step_core
    import mbt_pkg::*;
#(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               action,
    input  logic [RAND_W-1:0]  rand_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         move_kind,
    output logic [COORD_W-1:0] cell_x,
    output logic [COORD_W-1:0] cell_y,
    output logic [1:0]         carve_dir,
    output logic               finished,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [SIZE_W-1:0]  cfg_data
);

    localparam int LIM_COLS = (MAX_COLS < GRID_SIDE) ? MAX_COLS : GRID_SIDE;
    localparam int LIM_ROWS = (MAX_ROWS < GRID_SIDE) ? MAX_ROWS : GRID_SIDE;
    localparam logic [SIZE_W-1:0] LIM_COLS_S = SIZE_W'(LIM_COLS);
    localparam logic [SIZE_W-1:0] LIM_ROWS_S = SIZE_W'(LIM_ROWS);

    logic [SIZE_W-1:0] grid_width_reg;
    logic [SIZE_W-1:0] grid_height_reg;
    logic [SIZE_W-1:0] width_lim;
    logic [SIZE_W-1:0] height_lim;
    mbt_cmd_t          cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= GRID_WIDTH_RESET;
            grid_height_reg <= GRID_HEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_GRID_WIDTH:  grid_width_reg  <= cfg_data;
                REG_GRID_HEIGHT: grid_height_reg <= cfg_data;
                default:         grid_width_reg  <= grid_width_reg;
            endcase
        end
    end

    // A size of zero counts as one; sizes beyond the storage saturate.
    always_comb
    begin
        priority if (grid_width_reg == '0)
            width_lim = SIZE_W'(1);
        else if (grid_width_reg > LIM_COLS_S)
            width_lim = LIM_COLS_S;
        else
            width_lim = grid_width_reg;

        priority if (grid_height_reg == '0)
            height_lim = SIZE_W'(1);
        else if (grid_height_reg > LIM_ROWS_S)
            height_lim = LIM_ROWS_S;
        else
            height_lim = grid_height_reg;
    end

    mbt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    mbt_datapath #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .action     (action),
        .rand_value (rand_value),
        .width_lim  (width_lim),
        .height_lim (height_lim),
        .move_kind  (move_kind),
        .cell_x     (cell_x),
        .cell_y     (cell_y),
        .carve_dir  (carve_dir),
        .finished   (finished)
    );

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
    import mbt_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int ITEM_TARGET  = 1420;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 6;
    localparam int CELL_COUNT   = GRID_SIDE * GRID_SIDE;

    typedef struct packed {
        logic              act;
        logic [RAND_W-1:0] rnd;
    } stim_item_t;

    typedef struct packed {
        move_kind_t         kind;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        dir_t               dir;
        logic               fin;
    } move_t;

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               in_valid   = 1'b0;
    logic               in_stall;
    logic               action     = ACT_STEP;
    logic [RAND_W-1:0]  rand_value = '0;
    logic               out_valid;
    logic               out_stall  = 1'b0;
    logic [1:0]         move_kind;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic [1:0]         carve_dir;
    logic               finished;
    logic               cfg_valid  = 1'b0;
    logic               cfg_ready;
    logic               cfg_index  = REG_GRID_WIDTH;
    logic [SIZE_W-1:0]  cfg_data   = '0;

    // Predictor state, kept in step with the block at each accepted transaction.
    logic [SIZE_W-1:0]     grid_w_reg = GRID_WIDTH_RESET;
    logic [SIZE_W-1:0]     grid_h_reg = GRID_HEIGHT_RESET;
    logic [CELL_COUNT-1:0] maze_visited = '0;
    logic [CELL_W-1:0]     branch_cells [CELL_COUNT];
    int                    branch_depth = 0;
    logic [COORD_W-1:0]    cur_x = '0;
    logic [COORD_W-1:0]    cur_y = '0;
    logic                  maze_done = 1'b1;

    stim_item_t pending_items [$];
    move_t      expected_moves [$];
    stim_item_t staged_item;
    move_t      due_move;

    int   cycle_count    = 0;
    int   items_queued   = 0;
    int   items_accepted = 0;
    int   mismatch_count = 0;
    int   settings_count = 0;
    int   kind_seen [4]  = '{0, 0, 0, 0};
    int   hold_left      = 0;
    logic hold_request   = 1'b0;
    logic hold_done      = 1'b0;
    logic calm;

    assign calm = (cycle_count >= 1500) && (cycle_count < 4500);

    maze_backtracker_step_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .rand_value (rand_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .move_kind  (move_kind),
        .cell_x     (cell_x),
        .cell_y     (cell_y),
        .carve_dir  (carve_dir),
        .finished   (finished),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic int clamp_size(input logic [SIZE_W-1:0] value);
        if (value == '0)
        begin
            return 1;
        end
        if (value > GRID_SIDE)
        begin
            return GRID_SIDE;
        end
        return int'(value);
    endfunction

    function automatic move_t predict_move(input logic act, input logic [RAND_W-1:0] rnd);
        move_t res;
        int    w;
        int    h;
        int    nx;
        int    ny;
        int    count;
        int    slot;
        int    open_x [4];
        int    open_y [4];
        dir_t  open_dir [4];
        w        = clamp_size(grid_w_reg);
        h        = clamp_size(grid_h_reg);
        count    = 0;
        res.kind = MOVE_FINISHED;
        res.dir  = DIR_TOP;
        res.fin  = 1'b0;
        if (act == ACT_START)
        begin
            maze_visited    = '0;
            maze_visited[0] = 1'b1;
            branch_depth    = 0;
            cur_x           = '0;
            cur_y           = '0;
            maze_done       = 1'b0;
            res.kind        = MOVE_STARTED;
        end
        else if (maze_done)
        begin
            res.fin = 1'b1;
        end
        else
        begin
            // Both coordinates of each neighbour are tested against the bounds, so a cell left
            // outside a shrunken grid can open only neighbours that lie inside it.
            for (int d = 0; d < 4; d++)
            begin
                nx = int'(cur_x);
                ny = int'(cur_y);
                case (dir_t'(d))
                    DIR_TOP:    ny = ny - 1;
                    DIR_BOTTOM: ny = ny + 1;
                    DIR_EAST:   nx = nx + 1;
                    default:    nx = nx - 1;
                endcase
                if (nx >= 0 && nx < w && ny >= 0 && ny < h &&
                    !maze_visited[ny * GRID_SIDE + nx])
                begin
                    open_x[count]   = nx;
                    open_y[count]   = ny;
                    open_dir[count] = dir_t'(d);
                    count++;
                end
            end
            if (count == 0 && branch_depth == 0)
            begin
                maze_done = 1'b1;
                res.fin   = 1'b1;
            end
            else if (count == 0)
            begin
                branch_depth--;
                {cur_y, cur_x} = branch_cells[branch_depth];
                res.kind       = MOVE_BACKTRACK;
            end
            else
            begin
                if (count >= 2 && branch_depth < CELL_COUNT)
                begin
                    branch_cells[branch_depth] = {cur_y, cur_x};
                    branch_depth++;
                end
                slot  = int'(rnd) % count;
                cur_x = COORD_W'(open_x[slot]);
                cur_y = COORD_W'(open_y[slot]);
                maze_visited[open_y[slot] * GRID_SIDE + open_x[slot]] = 1'b1;
                res.kind = MOVE_CARVED;
                res.dir  = open_dir[slot];
            end
        end
        res.x = cur_x;
        res.y = cur_y;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < 50)
        begin
            $display("mismatch in %s: got %0d, expected %0d (cycle %0d)",
                     what, got, want, cycle_count);
        end
        mismatch_count++;
    endtask

    // Sender: holds a stalled transaction steady and predicts each accepted one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            action     <= ACT_STEP;
            rand_value <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_moves.push_back(predict_move(action, rand_value));
                items_accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_items.size() != 0 && (calm || $urandom_range(0, 99) >= 9))
                begin
                    staged_item = pending_items.pop_front();
                    in_valid   <= 1'b1;
                    action     <= staged_item.act;
                    rand_value <= staged_item.rnd;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall, with one long hold-off on request so that the block backs up.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_request && !hold_done)
        begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
        begin
            out_stall <= !calm && ($urandom_range(0, 99) < 9);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_moves.size() == 0)
            begin
                report_mismatch("unexpected result, move_kind", move_kind, -1);
            end
            else
            begin
                due_move = expected_moves.pop_front();
                kind_seen[due_move.kind]++;
                if (move_kind != due_move.kind)
                begin
                    report_mismatch("move_kind", move_kind, due_move.kind);
                end
                if (cell_x != due_move.x)
                begin
                    report_mismatch("cell_x", cell_x, due_move.x);
                end
                if (cell_y != due_move.y)
                begin
                    report_mismatch("cell_y", cell_y, due_move.y);
                end
                if (carve_dir != due_move.dir)
                begin
                    report_mismatch("carve_dir", carve_dir, due_move.dir);
                end
                if (finished != due_move.fin)
                begin
                    report_mismatch("finished", finished, due_move.fin);
                end
            end
        end
    end

    task automatic add_item(input logic act, input logic [RAND_W-1:0] rnd);
        stim_item_t item;
        item.act = act;
        item.rnd = rnd;
        pending_items.push_back(item);
        items_queued++;
    endtask

    task automatic write_reg(input logic idx, input logic [SIZE_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        if (idx == REG_GRID_WIDTH)
        begin
            grid_w_reg = value;
        end
        else
        begin
            grid_h_reg = value;
        end
    endtask

    task automatic set_size(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
        write_reg(REG_GRID_WIDTH, w);
        write_reg(REG_GRID_HEIGHT, h);
        settings_count++;
    endtask

    // Counts rather than the valid line decide idleness, so the check is free of
    // ordering within a time step.
    task automatic wait_idle();
        while (items_accepted != items_queued || expected_moves.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    initial
    begin
        int                phase_no;
        int                pick;
        int                area;
        int                step_total;
        logic [SIZE_W-1:0] w_set;
        logic [SIZE_W-1:0] h_set;
        logic [SIZE_W-1:0] swap_val;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Steps before any start, then a short walk on the default grid.
        add_item(ACT_STEP, 8'd0);
        add_item(ACT_STEP, 8'd255);
        add_item(ACT_START, 8'd0);
        add_item(ACT_STEP, 8'd0);
        add_item(ACT_STEP, 8'd255);
        add_item(ACT_STEP, 8'd128);
        wait_idle();

        // A zero width reads as one column; an oversized height saturates.
        set_size(7'd0, 7'd127);
        add_item(ACT_START, 8'd255);
        add_item(ACT_STEP, 8'd7);
        add_item(ACT_STEP, 8'd200);
        wait_idle();

        // A single cell finishes at once.
        set_size(7'd1, 7'd1);
        add_item(ACT_START, 8'd0);
        add_item(ACT_STEP, 8'd0);
        add_item(ACT_STEP, 8'd0);
        wait_idle();

        // Two by two: branch, carve round the loop, backtrack, finish.
        set_size(7'd2, 7'd2);
        add_item(ACT_START, 8'd0);
        add_item(ACT_STEP, 8'd1);
        add_item(ACT_STEP, 8'd0);
        add_item(ACT_STEP, 8'd0);
        add_item(ACT_STEP, 8'd0);
        add_item(ACT_STEP, 8'd0);
        add_item(ACT_STEP, 8'd9);
        wait_idle();

        // Shrink the grid under a maze in progress.
        set_size(7'd3, 7'd3);
        add_item(ACT_START, 8'd0);
        add_item(ACT_STEP, 8'd2);
        add_item(ACT_STEP, 8'd2);
        wait_idle();
        set_size(7'd1, 7'd1);
        add_item(ACT_STEP, 8'd3);
        add_item(ACT_STEP, 8'd3);
        wait_idle();

        phase_no = 0;
        while (items_queued < ITEM_TARGET)
        begin
            phase_no++;
            pick = $urandom_range(0, 9);
            if (phase_no == 5)
            begin
                w_set = 7'd64;
                h_set = 7'd64;
            end
            else if (pick == 0)
            begin
                w_set = SIZE_W'($urandom_range(0, 127));
                h_set = SIZE_W'($urandom_range(0, 127));
            end
            else if (pick == 1)
            begin
                case ($urandom_range(0, 3))
                    0:       w_set = 7'd0;
                    1:       w_set = 7'd1;
                    2:       w_set = 7'd64;
                    default: w_set = 7'd127;
                endcase
                h_set = SIZE_W'($urandom_range(1, 4));
                if ($urandom_range(0, 1) == 1)
                begin
                    swap_val = w_set;
                    w_set    = h_set;
                    h_set    = swap_val;
                end
            end
            else
            begin
                w_set = SIZE_W'($urandom_range(1, 8));
                h_set = SIZE_W'($urandom_range(1, 8));
            end
            set_size(w_set, h_set);

            area = clamp_size(w_set) * clamp_size(h_set);
            if (2 * area + 2 > 90)
            begin
                step_total = $urandom_range(40, 90);
            end
            else
            begin
                step_total = 2 * area + 2 + $urandom_range(0, 2);
            end
            if (phase_no == 5)
            begin
                step_total = 200;
                hold_request <= 1'b1;
            end

            // Now and then the maze carries on under the new size without a restart.
            if (phase_no == 5 || $urandom_range(0, 7) != 0)
            begin
                add_item(ACT_START, RAND_W'($urandom_range(0, 255)));
            end
            for (int i = 0; i < step_total; i++)
            begin
                add_item(($urandom_range(0, 39) == 0) ? ACT_START : ACT_STEP,
                         RAND_W'($urandom_range(0, 255)));
            end
            wait_idle();
        end

        if (expected_moves.size() != 0)
        begin
            report_mismatch("results never delivered", 0, expected_moves.size());
        end
        $display("summary: %0d transactions over %0d grid sizes, %0d mismatches",
                 items_accepted, settings_count, mismatch_count);
        $display("summary: %0d carved, %0d backtracked, %0d finished, %0d started",
                 kind_seen[MOVE_CARVED], kind_seen[MOVE_BACKTRACK],
                 kind_seen[MOVE_FINISHED], kind_seen[MOVE_STARTED]);
        if (mismatch_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/mbt_pkg.sv
hdl/mbt_ctrl.sv
hdl/mbt_datapath.sv
hdl/maze_backtracker_step_core.sv
sim/testbench.sv
